// ===== hw/rtl/pfr_pkg.sv =====
// Package for the packet frame receiver: line byte codes, event codes,
// register indexes and the shared types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

   localparam int unsigned MAX_NODES = 2;

   localparam logic [7:0] SYNC_BYTE  = 8'hE0;
   localparam logic [7:0] MARK_BYTE  = 8'hD0;
   localparam logic [7:0] BCAST_ADDR = 8'hFF;
   localparam logic [7:0] HOST_ADDR  = 8'h00;

   localparam logic [1:0] NODE_NONE = 2'd2;

   // Event codes reported with every item.
   localparam logic [2:0] EV_IGNORED   = 3'd0;
   localparam logic [2:0] EV_SYNC      = 3'd1;
   localparam logic [2:0] EV_ESCAPE    = 3'd2;
   localparam logic [2:0] EV_STORED    = 3'd3;
   localparam logic [2:0] EV_GOOD      = 3'd4;
   localparam logic [2:0] EV_SUM_REPLY = 3'd5;
   localparam logic [2:0] EV_SUM_HOST  = 3'd6;
   localparam logic [2:0] EV_FOREIGN   = 3'd7;

   // Register indexes (byte address bits [3:2]).
   localparam logic [1:0] REG_NODE_COUNT    = 2'd0;
   localparam logic [1:0] REG_FIRST_ADDRESS = 2'd1;
   localparam logic [1:0] REG_SECOND_ADDR   = 2'd2;
   localparam logic [1:0] REG_RESET_CMD     = 2'd3;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef struct packed {
      logic [1:0] node_count;
      logic [7:0] first_address;
      logic [7:0] second_address;
      logic [7:0] reset_command_code;
   } pfr_cfg_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] decoded_byte;
      logic [8:0] byte_position;
      logic [7:0] frame_length;
      logic [1:0] matched_node;
   } pfr_rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pfr_channels.sv =====
// Valid/ready channel interfaces for the packet frame receiver: the line
// byte input and the decoded result output. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface pfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;

   modport source (output valid, output line_byte, input ready);
   modport sink   (input valid, input line_byte, output ready);
endinterface

interface pfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] decoded_byte;
   logic [8:0] byte_position;
   logic [7:0] frame_length;
   logic [1:0] matched_node;

   modport source (output valid, output event_res, output decoded_byte,
                   output byte_position, output frame_length, output matched_node,
                   input ready);
   modport sink   (input valid, input event_res, input decoded_byte,
                   input byte_position, input frame_length, input matched_node,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pfr_csr.sv =====
// Configuration register file of the packet frame receiver, APB-style.
// Depends on pfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfr_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [pfr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [pfr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pfr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output pfr_pkg::pfr_cfg_type              cfg
);

   pfr_pkg::pfr_cfg_type cfg_ff;
   pfr_pkg::pfr_cfg_type cfg_in;
   logic                 wr_en;
   logic [1:0]           reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            pfr_pkg::REG_NODE_COUNT:    cfg_in.node_count         = csr_pwdata[1:0];
            pfr_pkg::REG_FIRST_ADDRESS: cfg_in.first_address      = csr_pwdata[7:0];
            pfr_pkg::REG_SECOND_ADDR:   cfg_in.second_address     = csr_pwdata[7:0];
            pfr_pkg::REG_RESET_CMD:     cfg_in.reset_command_code = csr_pwdata[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_count         <= 2'd1;
         cfg_ff.first_address      <= 8'd255;
         cfg_ff.second_address     <= 8'd255;
         cfg_ff.reset_command_code <= 8'd240;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_index)
         pfr_pkg::REG_NODE_COUNT:    csr_prdata[1:0] = cfg_ff.node_count;
         pfr_pkg::REG_FIRST_ADDRESS: csr_prdata[7:0] = cfg_ff.first_address;
         pfr_pkg::REG_SECOND_ADDR:   csr_prdata[7:0] = cfg_ff.second_address;
         pfr_pkg::REG_RESET_CMD:     csr_prdata[7:0] = cfg_ff.reset_command_code;
         default:                    csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/packet_frame_receiver_core.sv =====
// Top level of the packet frame receiver: frame state, byte decoding and
// the result register. Depends on pfr_pkg, pfr_channels and pfr_csr.
//
// The receiver takes one line byte per clock cycle and returns exactly one
// result item for each byte, in the cycle after the byte is accepted. All frame
// state (sync, escape, byte count, header fields and checksum) is updated by
// a single pass of logic at the accepting edge, and the result sits in an
// output register; a new byte is accepted whenever that register is empty
// or being emptied in the same cycle, so the sustained rate is one item per
// cycle and throughput is bounded only by the result channel's ready.
`timescale 1ns / 1ps
`default_nettype none

module packet_frame_receiver_core (
   input  wire                               clock,
   input  wire                               reset,
   pfr_req_if.sink                           req_ch,
   pfr_rsp_if.source                         rsp_ch,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [pfr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [pfr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pfr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   pfr_pkg::pfr_cfg_type cfg;

   pfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Frame state
   logic       receiving_ff, receiving_in;
   logic       escaping_ff, escaping_in;
   logic [8:0] count_ff, count_in;
   logic [7:0] dest_ff, dest_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] sum_ff, sum_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   pfr_pkg::pfr_rsp_type rsp_ff, rsp_in;

   logic       accept;
   logic [7:0] b;
   logic [7:0] val;
   logic [8:0] count_next;
   logic [8:0] frame_end;
   logic       frame_done;
   logic       bcast_reset;
   logic [1:0] node_hit;
   logic       two_nodes;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.line_byte;

   // A node count of 0 behaves as 1, anything above two as two.
   assign two_nodes = (cfg.node_count >= 2'd2);

   always_comb begin
      receiving_in = receiving_ff;
      escaping_in  = escaping_ff;
      count_in     = count_ff;
      dest_in      = dest_ff;
      length_in    = length_ff;
      command_in   = command_ff;
      sum_in       = sum_ff;

      val         = escaping_ff ? (b + 8'd1) : b;
      count_next  = count_ff + 9'd1;
      frame_end   = 9'd0;
      frame_done  = 1'b0;
      bcast_reset = 1'b0;
      node_hit    = pfr_pkg::NODE_NONE;

      rsp_in.event_res     = pfr_pkg::EV_IGNORED;
      rsp_in.decoded_byte  = '0;
      rsp_in.byte_position = '0;
      rsp_in.frame_length  = '0;
      rsp_in.matched_node  = pfr_pkg::NODE_NONE;

      priority if (b == pfr_pkg::SYNC_BYTE) begin
         rsp_in.event_res = pfr_pkg::EV_SYNC;
         receiving_in     = 1'b1;
         escaping_in      = 1'b0;
         count_in         = '0;
         sum_in           = '0;
      end else if (!receiving_ff) begin
         rsp_in.event_res = pfr_pkg::EV_IGNORED;
      end else if (b == pfr_pkg::MARK_BYTE) begin
         rsp_in.event_res = pfr_pkg::EV_ESCAPE;
         escaping_in      = 1'b1;
      end else begin
         escaping_in = 1'b0;
         // Header bytes are captured by position before the end check uses them.
         if (count_ff == 9'd0) dest_in    = val;
         if (count_ff == 9'd1) length_in  = val;
         if (count_ff == 9'd2) command_in = val;
         count_in = count_next;
         sum_in   = sum_ff + val;

         rsp_in.event_res     = pfr_pkg::EV_STORED;
         rsp_in.decoded_byte  = val;
         rsp_in.byte_position = count_ff;
         rsp_in.frame_length  = length_in;

         frame_end  = {1'b0, length_in} + 9'd2;
         frame_done = (count_next >= 9'd2) && (frame_end == count_next);

         if (two_nodes && (cfg.second_address == dest_in)) begin
            node_hit = 2'd1;
         end else if (cfg.first_address == dest_in) begin
            node_hit = 2'd0;
         end
         bcast_reset = (dest_in == pfr_pkg::BCAST_ADDR) &&
                       (command_in == cfg.reset_command_code);

         if (frame_done) begin
            rsp_in.matched_node = node_hit;
            if (bcast_reset || (node_hit != pfr_pkg::NODE_NONE)) begin
               receiving_in = 1'b0;
               if (val == sum_ff) begin
                  rsp_in.event_res = pfr_pkg::EV_GOOD;
               end else begin
                  rsp_in.event_res = (cfg.first_address == pfr_pkg::HOST_ADDR) ?
                                     pfr_pkg::EV_SUM_HOST : pfr_pkg::EV_SUM_REPLY;
                  count_in = '0;
                  sum_in   = '0;
               end
            end else begin
               // Someone else's frame: keep listening for the next one.
               rsp_in.event_res = pfr_pkg::EV_FOREIGN;
               count_in = '0;
               sum_in   = '0;
            end
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         escaping_ff  <= 1'b0;
         count_ff     <= '0;
         dest_ff      <= '0;
         length_ff    <= '0;
         command_ff   <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            receiving_ff <= receiving_in;
            escaping_ff  <= escaping_in;
            count_ff     <= count_in;
            dest_ff      <= dest_in;
            length_ff    <= length_in;
            command_ff   <= command_in;
            sum_ff       <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.event_res     = rsp_ff.event_res;
   assign rsp_ch.decoded_byte  = rsp_ff.decoded_byte;
   assign rsp_ch.byte_position = rsp_ff.byte_position;
   assign rsp_ch.frame_length  = rsp_ff.frame_length;
   assign rsp_ch.matched_node  = rsp_ff.matched_node;

endmodule

`default_nettype wire

// ===== tb/tb_packet_frame_receiver_core.sv =====
// Self-checking testbench for packet_frame_receiver_core: frame and escape
// decoding, checksum and address checks, with stalls on both channels.
// Depends on pfr_pkg, pfr_channels and the core itself.
`timescale 1ns / 1ps

module tb_packet_frame_receiver_core;
   import pfr_pkg::*;

   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned PHASE_BYTES     = 50;
   localparam int unsigned PHASES          = 6;

   // Positions of the header bytes within a decoded frame.
   localparam int unsigned POS_DESTINATION = 0;
   localparam int unsigned POS_LENGTH      = 1;
   localparam int unsigned POS_COMMAND     = 2;

   // Tracks the deframer state and the result each line byte must produce.
   class frame_event_tracker;
      logic [1:0] node_count;
      logic [7:0] first_address;
      logic [7:0] second_address;
      logic [7:0] reset_command_code;
      bit         receiving;
      bit         escaping;
      logic [8:0] byte_count;
      logic [7:0] frame_destination;
      logic [7:0] length_field;
      logic [7:0] first_command;
      logic [7:0] running_sum;
      pfr_rsp_type pending_events[$];
      int unsigned mismatches;

      function new();
         node_count         = 2'd1;
         first_address      = 8'hFF;
         second_address     = 8'hFF;
         reset_command_code = 8'hF0;
         receiving          = 1'b0;
         escaping           = 1'b0;
         byte_count         = '0;
         frame_destination  = '0;
         length_field       = '0;
         first_command      = '0;
         running_sum        = '0;
         mismatches         = 0;
      endfunction

      function void set_register(input logic [1:0] index, input logic [7:0] value);
         case (index)
            REG_NODE_COUNT:    node_count = value[1:0];
            REG_FIRST_ADDRESS: first_address = value;
            REG_SECOND_ADDR:   second_address = value;
            REG_RESET_CMD:     reset_command_code = value;
            default: ;
         endcase
      endfunction

      // Highest matching node index wins; unused node slots never match.
      function logic [1:0] match_node(input logic [7:0] dest);
         logic [7:0]  addresses [MAX_NODES];
         int unsigned in_use;
         int unsigned slot;
         logic [1:0]  hit;
         addresses[0] = first_address;
         addresses[1] = second_address;
         in_use = (node_count == 0) ? 1 :
                  (node_count > MAX_NODES) ? MAX_NODES : node_count;
         hit = NODE_NONE;
         for (slot = 0; slot < in_use; slot++)
            if (addresses[slot] == dest) hit = 2'(slot);
         return hit;
      endfunction

      function void note_line_byte(input logic [7:0] line);
         pfr_rsp_type outcome;
         logic [7:0]  prior_sum;
         bit          reset_broadcast;
         outcome = '0;
         outcome.matched_node = NODE_NONE;
         if (line == SYNC_BYTE) begin
            outcome.event_res = EV_SYNC;
            receiving   = 1'b1;
            escaping    = 1'b0;
            byte_count  = '0;
            running_sum = '0;
         end else if (!receiving) begin
            outcome.event_res = EV_IGNORED;
         end else if (line == MARK_BYTE) begin
            outcome.event_res = EV_ESCAPE;
            escaping = 1'b1;
         end else begin
            prior_sum = running_sum;
            outcome.decoded_byte = escaping ? line + 8'd1 : line;
            escaping = 1'b0;
            outcome.byte_position = byte_count;
            if (byte_count == POS_DESTINATION) frame_destination = outcome.decoded_byte;
            else if (byte_count == POS_LENGTH) length_field = outcome.decoded_byte;
            else if (byte_count == POS_COMMAND) first_command = outcome.decoded_byte;
            byte_count  = byte_count + 9'd1;
            running_sum = running_sum + outcome.decoded_byte;
            outcome.frame_length = length_field;
            outcome.event_res = EV_STORED;
            if (byte_count >= 2 && int'(length_field) + 2 == int'(byte_count)) begin
               reset_broadcast = (frame_destination == BCAST_ADDR) &&
                                 (first_command == reset_command_code);
               outcome.matched_node = match_node(frame_destination);
               if (reset_broadcast || outcome.matched_node != NODE_NONE) begin
                  receiving = 1'b0;
                  if (outcome.decoded_byte == prior_sum) begin
                     outcome.event_res = EV_GOOD;
                  end else begin
                     outcome.event_res = (first_address == HOST_ADDR) ?
                                         EV_SUM_HOST : EV_SUM_REPLY;
                     byte_count  = '0;
                     running_sum = '0;
                  end
               end else begin
                  // Frame for another node: keep listening, count from zero.
                  outcome.event_res = EV_FOREIGN;
                  byte_count  = '0;
                  running_sum = '0;
               end
            end
         end
         pending_events.push_back(outcome);
      endfunction

      function void compare_field(input string field, input logic [8:0] want,
                                  input logic [8:0] got);
         if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_event(input pfr_rsp_type got);
         pfr_rsp_type want;
         if (pending_events.size() == 0) begin
            $display("%0t: result expected none, got 0x%0h", $time, got);
            mismatches++;
            return;
         end
         want = pending_events.pop_front();
         compare_field("event_res", 9'(want.event_res), 9'(got.event_res));
         compare_field("decoded_byte", 9'(want.decoded_byte), 9'(got.decoded_byte));
         compare_field("byte_position", want.byte_position, got.byte_position);
         compare_field("frame_length", 9'(want.frame_length), 9'(got.frame_length));
         compare_field("matched_node", 9'(want.matched_node), 9'(got.matched_node));
      endfunction

      function int unsigned outstanding();
         return pending_events.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   wire  [CSR_DATA_W-1:0] csr_prdata;
   wire  csr_pready;

   pfr_req_if req_if();
   pfr_rsp_if rsp_if();

   frame_event_tracker tracker;
   int unsigned burst_left;
   int unsigned bytes_sent;
   int unsigned quiet_cycles;
   bit          hold_off_req;

   packet_frame_receiver_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin : channel_monitor
      pfr_rsp_type observed;
      if (!reset) begin
         if (req_if.valid && req_if.ready) tracker.note_line_byte(req_if.line_byte);
         if (rsp_if.valid && rsp_if.ready) begin
            observed = {rsp_if.event_res, rsp_if.decoded_byte, rsp_if.byte_position,
                        rsp_if.frame_length, rsp_if.matched_node};
            tracker.check_event(observed);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_psel && csr_penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin : watchdog
      quiet_cycles = 0;
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("tb_packet_frame_receiver_core failed");
      $finish;
   end

   // Result side: changing stall patterns, plus one long hold-off on request.
   initial begin : rsp_stall_pattern
      int unsigned mode;
      int unsigned span;
      int unsigned beat;
      beat = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         repeat (span) begin
            // A hold-off request starts right away, while bytes are still coming.
            if (hold_off_req) break;
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= (beat % 3 != 2);
            endcase
            beat++;
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) :
                                                     $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      bytes_sent++;
      req_if.valid <= 1'b1;
      req_if.line_byte <= value;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Sync and marker values must be escaped inside a frame; others bar E1/D1 sometimes are.
   task automatic send_decoded(input logic [7:0] value);
      if (value == SYNC_BYTE || value == MARK_BYTE ||
          (value != SYNC_BYTE + 8'd1 && value != MARK_BYTE + 8'd1 &&
           $urandom_range(0, 9) == 0)) begin
         send_byte(MARK_BYTE);
         send_byte(value - 8'd1);
      end else begin
         send_byte(value);
      end
   endtask

   task automatic send_frame(input logic [7:0] len);
      logic [7:0]  dest;
      logic [7:0]  sum;
      logic [7:0]  data;
      int unsigned pick;
      int unsigned cut;
      int          pos;
      bit          bad_sum;
      bit          reset_broadcast;
      pick = $urandom_range(0, 99);
      reset_broadcast = 1'b0;
      if (pick < 40) begin
         dest = tracker.first_address;
      end else if (pick < 60) begin
         dest = tracker.second_address;
      end else if (pick < 80) begin
         dest = BCAST_ADDR;
         reset_broadcast = $urandom_range(0, 1);
      end else begin
         dest = 8'($urandom);
      end
      bad_sum = ($urandom_range(0, 7) == 0);
      // A few frames are cut short and followed by whatever comes next.
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len + 1) : len + 2;
      if ($urandom_range(0, 9) != 0) send_byte(SYNC_BYTE);
      sum = '0;
      for (pos = 0; pos < len + 2 && pos < cut; pos++) begin
         if (pos == POS_DESTINATION) data = dest;
         else if (pos == POS_LENGTH) data = len;
         else if (pos == len + 1) data = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
         else if (pos == POS_COMMAND && reset_broadcast) data = tracker.reset_command_code;
         else data = 8'($urandom);
         send_decoded(data);
         sum = sum + data;
      end
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.set_register(index, value);
   endtask

   // Stops offering items and waits for every outstanding result.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tracker.outstanding() != 0);
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned phase_start;
      logic [7:0]  shared_address;
      tracker = new();
      burst_left   = 0;
      bytes_sent   = 0;
      hold_off_req = 1'b0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.line_byte <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: one node at address 0xFF.
      send_byte(8'h00);              // ignored before any sync
      send_byte(8'hFF);
      send_byte(SYNC_BYTE);
      send_byte(8'h01);              // foreign destination, length zero
      send_byte(8'h00);
      send_byte(8'hFF);              // counting restarted: short frame, bad sum
      send_byte(8'h00);
      send_byte(SYNC_BYTE);
      send_byte(MARK_BYTE);
      send_byte(8'hFE);              // escaped destination 0xFF
      send_byte(8'h01);              // length one: checksum becomes the command
      send_byte(8'h00);
      send_byte(SYNC_BYTE);
      send_byte(MARK_BYTE);
      send_byte(MARK_BYTE);          // a marker after a marker escapes again
      send_byte(SYNC_BYTE);          // sync cancels the pending escape
      send_byte(8'hFF);
      send_byte(8'h02);
      send_byte(MARK_BYTE);
      send_byte(8'hDF);              // payload value equal to the sync code
      send_byte(8'hE1);              // good checksum
      drain_results();
      write_register(REG_FIRST_ADDRESS, HOST_ADDR);
      send_byte(SYNC_BYTE);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(MARK_BYTE);
      send_byte(8'hFF);              // escape wraps to zero: checksum error in host mode

      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         shared_address = 8'($urandom_range(1, 254));
         case (phase)
            0: begin
               write_register(REG_NODE_COUNT, 8'd2);
               write_register(REG_FIRST_ADDRESS, 8'($urandom_range(1, 254)));
               write_register(REG_SECOND_ADDR, 8'($urandom));
               write_register(REG_RESET_CMD, 8'($urandom));
            end
            1: begin
               write_register(REG_NODE_COUNT, 8'd0);
               write_register(REG_FIRST_ADDRESS, HOST_ADDR);
               write_register(REG_SECOND_ADDR, 8'hFF);
               write_register(REG_RESET_CMD, 8'h00);
            end
            2: begin
               write_register(REG_NODE_COUNT, 8'd3);
               write_register(REG_FIRST_ADDRESS, 8'hFF);
               write_register(REG_SECOND_ADDR, HOST_ADDR);
               write_register(REG_RESET_CMD, 8'hFF);
            end
            3: begin
               write_register(REG_NODE_COUNT, 8'd1);
               write_register(REG_FIRST_ADDRESS, shared_address);
               write_register(REG_SECOND_ADDR, shared_address);
               write_register(REG_RESET_CMD, 8'($urandom));
            end
            4: begin
               write_register(REG_NODE_COUNT, 8'd2);
               write_register(REG_FIRST_ADDRESS, shared_address);
               write_register(REG_SECOND_ADDR, shared_address);
               write_register(REG_RESET_CMD, 8'($urandom));
            end
            default: begin
               write_register(REG_NODE_COUNT, 8'($urandom_range(0, 3)));
               write_register(REG_FIRST_ADDRESS, 8'($urandom));
               write_register(REG_SECOND_ADDR, 8'($urandom));
               write_register(REG_RESET_CMD, 8'($urandom));
            end
         endcase
         // The result side stops for a long stretch while bytes keep coming.
         if (phase == 0) hold_off_req = 1'b1;
         // Longest frame: its checksum sits at position 256.
         if (phase == 2) send_frame(8'd255);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            if ($urandom_range(0, 9) == 0)
               send_frame(8'($urandom_range(0, 1)));
            else
               send_frame(8'($urandom_range(2, 12)));
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("tb_packet_frame_receiver_core passed");
      else
         $display("tb_packet_frame_receiver_core failed");
      $finish;
   end

endmodule
